/* design/strided_gather_to_float_macros.svh */
// assertion macros for the strided gather block
`ifndef STRIDED_GATHER_TO_FLOAT_MACROS_SVH
`define STRIDED_GATHER_TO_FLOAT_MACROS_SVH
// a implies b at the same edge
`define SGF_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("failed");
// a implies b at the next edge
`define SGF_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("failed");
`endif

/* design/sgf_pkg.sv */
// ----------------------------------------------------------------------------
// sgf_pkg
// types, codes and a type check helper shared by the gather block
// ----------------------------------------------------------------------------
package sgf_pkg;
  localparam int AddrBits = 48;
  localparam int GroupSize = 8;

  localparam logic [7:0] TYPE_DOUBLE = 8'd13;
  localparam logic [7:0] TYPE_FLOAT = 8'd15;
  localparam logic [7:0] TYPE_S32 = 8'd32;
  localparam logic [7:0] TYPE_S16 = 8'd16;
  localparam logic [7:0] TYPE_S8 = 8'd8;
  localparam logic [7:0] TYPE_U32 = 8'd132;
  localparam logic [7:0] TYPE_U16 = 8'd116;
  localparam logic [7:0] TYPE_U8 = 8'd108;

  localparam logic [2:0] REG_BASE = 3'd0;
  localparam logic [2:0] REG_ROWLEN = 3'd1;
  localparam logic [2:0] REG_ISTRIDE = 3'd2;
  localparam logic [2:0] REG_OSTRIDE = 3'd3;
  localparam logic [2:0] REG_TYPE = 3'd4;
  localparam logic [2:0] REG_ATOTAL = 3'd5;
  localparam logic [2:0] REG_ANUM = 3'd6;

  // commands from controller to datapath
  typedef struct packed {
    logic div_start;  // load divider with start / row length
    logic div_step;   // one quotient bit
    logic addr_mul;   // row * outer stride (product step)
    logic addr_first; // first address from row start and column
    logic data_load;  // capture raw element
    logic conv_norm;  // normalize step
    logic conv_round; // round and pack
    logic advance;    // step position after a value
  } sgf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic norm_done;
    logic last;       // this value ends the run
  } sgf_sts_t;

  function automatic logic type_known(input logic [7:0] t);
    return t inside {TYPE_DOUBLE, TYPE_FLOAT, TYPE_S32, TYPE_S16, TYPE_S8,
                     TYPE_U32, TYPE_U16, TYPE_U8};
  endfunction
endpackage

/* design/sgf_datapath.sv */
// ----------------------------------------------------------------------------
// sgf_datapath
// divider, address walk and float conversion registers
// ----------------------------------------------------------------------------
module sgf_datapath (
  input  logic                            clk,
  input  sgf_pkg::sgf_cmd_t               cmd,
  output sgf_pkg::sgf_sts_t               sts,
  input  logic [47:0]                     base_address,
  input  logic [31:0]                     row_length,
  input  logic [31:0]                     inner_stride,
  input  logic [31:0]                     outer_stride,
  input  logic [7:0]                      element_type,
  input  logic [15:0]                     array_total,
  input  logic [15:0]                     array_number,
  input  logic [31:0]                     start_element,
  input  logic [31:0]                     element_count,
  input  logic [63:0]                     raw_element,
  output logic [47:0]                     fetch_address,
  output logic [31:0]                     converted_value,
  output logic [47:0]                     dest_slot
);
  import sgf_pkg::*;

  logic [31:0] rl;
  logic [31:0] quo, rem_q, dividend;
  logic [5:0]  div_cnt;
  logic [32:0] rem_try;
  logic [47:0] row_start, elem_addr;
  logic [31:0] col, done_cnt, run_len;
  logic [47:0] slot_base;
  logic [2:0]  slot_low;

  // conversion state
  logic        c_sign;
  logic [63:0] c_mag;
  logic signed [12:0] c_exp;
  logic        c_zero, c_special;
  logic [31:0] c_special_bits;

  assign rl = (row_length == '0) ? 32'd1 : row_length;
  assign rem_try = {rem_q, dividend[31]} - {1'b0, rl};
  assign sts.div_done = (div_cnt == 6'd32);
  assign sts.norm_done = c_mag[63] | c_zero;
  assign sts.last = (done_cnt + 32'd1 == run_len);

  // restoring divider, one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dividend <= start_element;
      rem_q <= '0;
      quo <= '0;
      div_cnt <= '0;
      run_len <= element_count;
    end else if (cmd.div_step) begin
      dividend <= dividend << 1;
      div_cnt <= div_cnt + 6'd1;
      if (!rem_try[32]) begin
        rem_q <= rem_try[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], dividend[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  logic [63:0] row_prod, col_prod;
  assign row_prod = $signed({1'b0, quo}) * $signed(outer_stride);
  assign col_prod = $signed({1'b0, rem_q}) * $signed(inner_stride);

  always_ff @(posedge clk) begin
    if (cmd.addr_mul) begin
      row_start <= base_address + row_prod[47:0];
      elem_addr <= col_prod[47:0];
      col <= rem_q;
      done_cnt <= '0;
      slot_base <= {29'd0, array_number, 3'd0};
      slot_low <= '0;
    end else if (cmd.addr_first) begin
      elem_addr <= row_start + elem_addr;
    end else if (cmd.advance) begin
      done_cnt <= done_cnt + 32'd1;
      if (slot_low == 3'd7) begin
        slot_base <= slot_base + {29'd0, array_total, 3'd0};
      end
      slot_low <= slot_low + 3'd1;
      if (col + 32'd1 >= rl) begin
        col <= '0;
        row_start <= row_start + {{16{outer_stride[31]}}, outer_stride};
        elem_addr <= row_start + {{16{outer_stride[31]}}, outer_stride};
      end else begin
        col <= col + 32'd1;
        elem_addr <= elem_addr + {{16{inner_stride[31]}}, inner_stride};
      end
    end
  end

  assign fetch_address = elem_addr;

  // conversion: load, then normalize one bit a cycle, or 8 bits a step while the top byte is zero
  logic [10:0] de;
  logic [51:0] dm;
  assign de = raw_element[62:52];
  assign dm = raw_element[51:0];

  always_ff @(posedge clk) begin
    if (cmd.data_load) begin
      case (element_type)
        TYPE_DOUBLE: begin
          c_special <= (de == 11'h7ff);
          c_special_bits <= (de != 11'h7ff) ? 32'd0
                          : (dm == 0) ? {raw_element[63], 31'h7f800000}
                          : {raw_element[63], 8'hff, 1'b1, dm[50:29]};
          c_sign <= raw_element[63];
          c_mag <= {11'd0, de != 0, dm};
          c_exp <= $signed({2'b0, (de != 0) ? de : 11'd1}) - 13'sd1075 + 13'sd52 + 13'sd11;
        end
        TYPE_FLOAT: begin
          c_special <= 1'b1;
          c_special_bits <= raw_element[31:0];
          c_sign <= 1'b0;
          c_mag <= '0;
          c_exp <= 13'sd0;
        end
        TYPE_S32: begin
          c_special <= 1'b0;
          c_special_bits <= '0;
          c_sign <= raw_element[31];
          c_mag <= {raw_element[31] ? 32'd0 - raw_element[31:0] : raw_element[31:0], 32'd0};
          c_exp <= 13'sd31;
        end
        TYPE_S16: begin
          c_special <= 1'b0;
          c_special_bits <= '0;
          c_sign <= raw_element[15];
          c_mag <= {raw_element[15] ? 16'd0 - raw_element[15:0] : raw_element[15:0], 48'd0};
          c_exp <= 13'sd15;
        end
        TYPE_S8: begin
          c_special <= 1'b0;
          c_special_bits <= '0;
          c_sign <= raw_element[7];
          c_mag <= {raw_element[7] ? 8'd0 - raw_element[7:0] : raw_element[7:0], 56'd0};
          c_exp <= 13'sd7;
        end
        TYPE_U32: begin
          c_special <= 1'b0;
          c_special_bits <= '0;
          c_sign <= 1'b0;
          c_mag <= {raw_element[31:0], 32'd0};
          c_exp <= 13'sd31;
        end
        TYPE_U16: begin
          c_special <= 1'b0;
          c_special_bits <= '0;
          c_sign <= 1'b0;
          c_mag <= {raw_element[15:0], 48'd0};
          c_exp <= 13'sd15;
        end
        default: begin
          c_special <= 1'b0;
          c_special_bits <= '0;
          c_sign <= 1'b0;
          c_mag <= {raw_element[7:0], 56'd0};
          c_exp <= 13'sd7;
        end
      endcase
    end else if (cmd.conv_norm) begin
      if (c_mag[63:56] == 8'd0) begin
        c_mag <= c_mag << 8;
        c_exp <= c_exp - 13'sd8;
      end else begin
        c_mag <= c_mag << 1;
        c_exp <= c_exp - 13'sd1;
      end
    end
  end
  assign c_zero = (c_mag == '0);

  // round and pack: value = c_mag * 2^(c_exp-63), c_mag[63] set
  logic signed [12:0] fe;
  logic [6:0]  sh;
  logic [63:0] shifted, remn, half;
  logic [24:0] q;
  logic [31:0] packed_bits, mag_bits;
  always_comb begin
    fe = c_exp + 13'sd127;
    if (fe >= 13'sd1) sh = 7'd40;
    else if (fe < -13'sd30) sh = 7'd70;
    else sh = 7'(13'sd41 - fe);
    shifted = (sh >= 7'd64) ? 64'd0 : c_mag >> sh;
    remn = (sh >= 7'd64) ? c_mag : c_mag & ((64'd1 << sh) - 64'd1);
    half = (sh > 7'd64) ? 64'd0 : (sh == 7'd64) ? 64'h8000000000000000
         : (64'd1 << (sh - 7'd1));
    q = shifted[24:0];
    if (sh <= 7'd64 && (remn > half || (remn == half && q[0]))) q = q + 25'd1;
    if (fe >= 13'sd1) begin
      mag_bits = {1'b0, fe[7:0] - 8'd1, 23'd0} + {7'd0, q};
      if (fe >= 13'sd255 || mag_bits >= 32'h7f800000) mag_bits = 32'h7f800000;
    end else begin
      mag_bits = {7'd0, q};
    end
    packed_bits = c_special ? c_special_bits
                : c_zero ? {c_sign, 31'd0} : {c_sign, mag_bits[30:0]};
  end

  // value and its slot are captured before the walk steps on
  always_ff @(posedge clk) begin
    if (cmd.conv_round) begin
      converted_value <= packed_bits;
      dest_slot <= slot_base + {45'd0, slot_low};
    end
  end
endmodule

/* design/sgf_ctrl.sv */
// ----------------------------------------------------------------------------
// sgf_ctrl
// sequencer for start, fetch and convert phases, owns output handshake
// ----------------------------------------------------------------------------
module sgf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [31:0]        element_count,
  input  logic [7:0]         element_type,
  output logic               out_valid,
  input  logic               out_stall,
  output sgf_pkg::sgf_cmd_t  cmd,
  input  sgf_pkg::sgf_sts_t  sts,
  output logic               fetch_valid,
  output logic               value_valid,
  output logic               done_res,
  output logic               type_error,
  output logic               busy
);
  import sgf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_ADDR  = 7'b0001000,
    S_NORM  = 7'b0010000,
    S_ROUND = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_fire;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (accept) begin
        if (!action) begin
          if (type_known(element_type) && element_count != '0) begin
            cmd.div_start = 1'b1;
            state_next = S_DIV;
          end else begin
            state_next = S_OUT;
          end
        end else if (busy) begin
          if (type_known(element_type)) begin
            cmd.data_load = 1'b1;
            state_next = S_NORM;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_MUL;
        else cmd.div_step = 1'b1;
      end
      S_MUL: begin
        cmd.addr_mul = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr_first = 1'b1;
        state_next = S_OUT;
      end
      S_NORM: begin
        if (sts.norm_done) state_next = S_ROUND;
        else cmd.conv_norm = 1'b1;
      end
      S_ROUND: begin
        cmd.conv_round = 1'b1;
        cmd.advance = !sts.last;
        state_next = S_OUT;
      end
      S_OUT: if (out_fire) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      out_valid <= 1'b0;
      fetch_valid <= 1'b0;
      value_valid <= 1'b0;
      done_res <= 1'b0;
      type_error <= 1'b0;
    end else begin
      state <= state_next;
      if (out_fire) out_valid <= 1'b0;
      if (state == S_IDLE && accept) begin
        fetch_valid <= 1'b0;
        value_valid <= 1'b0;
        done_res <= 1'b0;
        type_error <= 1'b0;
        if (!action) begin
          busy <= 1'b0;
          if (!type_known(element_type)) begin
            type_error <= 1'b1;
            out_valid <= 1'b1;
          end else if (element_count == '0) begin
            done_res <= 1'b1;
            out_valid <= 1'b1;
          end
        end else if (busy && !type_known(element_type)) begin
          busy <= 1'b0;
          type_error <= 1'b1;
          out_valid <= 1'b1;
        end
      end
      if (state == S_ADDR) begin
        busy <= 1'b1;
        fetch_valid <= 1'b1;
        out_valid <= 1'b1;
      end
      if (state == S_ROUND) begin
        value_valid <= 1'b1;
        out_valid <= 1'b1;
        if (sts.last) begin
          done_res <= 1'b1;
          busy <= 1'b0;
        end else begin
          fetch_valid <= 1'b1;
        end
      end
    end
  end

  // fetch address of a continuing run is valid once advance has stepped it
endmodule

/* design/strided_gather_to_float.sv */
// ----------------------------------------------------------------------------
// strided_gather_to_float
// two-dimensional strided gather with conversion of elements to ieee single
// ----------------------------------------------------------------------------
// start item: 32-step divider, then multiply, then add before the result
// data item: load, normalize eight bits or one bit a step, then round
// one item at a time; next item taken the cycle after its result is taken
// rst is synchronous active high: idle, control and configuration registers back to reset values
module strided_gather_to_float (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] start_element,
  input  logic [31:0] element_count,
  input  logic [63:0] raw_element,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        fetch_valid,
  output logic [47:0] fetch_address,
  output logic        value_valid,
  output logic [31:0] converted_value,
  output logic [47:0] dest_slot,
  output logic        done_res,
  output logic        type_error
);
  import sgf_pkg::*;
  `include "strided_gather_to_float_macros.svh"

  // configuration registers
  logic [47:0] base_address;
  logic [31:0] row_length, inner_stride, outer_stride;
  logic [7:0]  element_type;
  logic [15:0] array_total, array_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      row_length <= 32'd1;
      inner_stride <= '0;
      outer_stride <= '0;
      element_type <= TYPE_DOUBLE;
      array_total <= 16'd1;
      array_number <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE:    base_address <= cfg_data;
        REG_ROWLEN:  row_length <= cfg_data[31:0];
        REG_ISTRIDE: inner_stride <= cfg_data[31:0];
        REG_OSTRIDE: outer_stride <= cfg_data[31:0];
        REG_TYPE:    element_type <= cfg_data[7:0];
        REG_ATOTAL:  array_total <= cfg_data[15:0];
        REG_ANUM:    array_number <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  sgf_cmd_t cmd;
  sgf_sts_t sts;
  logic     busy;
  logic [47:0] addr_raw, slot_raw;
  logic [31:0] value_raw;

  sgf_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .action, .element_count, .element_type,
    .out_valid, .out_stall, .cmd, .sts, .fetch_valid, .value_valid,
    .done_res, .type_error, .busy
  );

  sgf_datapath u_dp (
    .clk, .cmd, .sts, .base_address, .row_length, .inner_stride,
    .outer_stride, .element_type, .array_total, .array_number,
    .start_element, .element_count, .raw_element,
    .fetch_address(addr_raw), .converted_value(value_raw), .dest_slot(slot_raw)
  );

  // the walk steps while the value is rounded, so a continuing value result
  // already names the next element
  // fields zero where they carry no meaning
  assign fetch_address = fetch_valid ? addr_raw : '0;
  assign converted_value = value_valid ? value_raw : '0;
  assign dest_slot = value_valid ? slot_raw : '0;

  `SGF_ASSERT_IMP(a_err_alone, out_valid && type_error, !fetch_valid && !value_valid)
  `SGF_ASSERT_IMP(a_stall_busy, out_valid, in_stall)
  `SGF_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)
endmodule

/* dv/strided_gather_to_float_tb.sv */
// ----------------------------------------------------------------------------
// strided_gather_to_float_tb
// self-checking bench: directed table then random gather runs, each result
// compared field by field against a listed expectation or a behavioral predictor of the gather
// ----------------------------------------------------------------------------
module strided_gather_to_float_tb;
  import sgf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_ITEMS = 400;
  localparam logic [7:0] TYPE_UNKNOWN = 8'd200;

  typedef struct packed {
    logic        fv;
    logic [47:0] addr;
    logic        vv;
    logic [31:0] val;
    logic [47:0] slot;
    logic        done;
    logic        err;
  } gather_res_t;

  typedef struct packed {
    logic [7:0]  etype;
    logic        act;
    logic [31:0] st;
    logic [31:0] cnt;
    logic [63:0] raw;
    logic        typed;
    gather_res_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        action;
  logic [31:0] start_element;
  logic [31:0] element_count;
  logic [63:0] raw_element;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        out_valid;
  logic        out_stall;
  logic        fetch_valid;
  logic [47:0] fetch_address;
  logic        value_valid;
  logic [31:0] converted_value;
  logic [47:0] dest_slot;
  logic        done_res;
  logic        type_error;

  strided_gather_to_float uut (.*);

  // predictor copy of the registers
  logic [47:0] p_base;
  logic [31:0] p_rowlen;
  logic [31:0] p_istride;
  logic [31:0] p_ostride;
  logic [7:0]  p_etype;
  logic [15:0] p_atotal;
  logic [15:0] p_anum;
  // predictor copy of the walk state
  logic [47:0] row_addr;
  logic [47:0] elem_addr;
  logic [31:0] col_pos;
  logic [31:0] done_cnt;
  logic [31:0] run_len;
  logic        run_active;

  gather_res_t pending_results[$];
  stim_row_t   stim_rows[$];
  int          fail_count;
  int          item_count;
  int          idle_cycles;
  bit          calm;  // no idling on either side while set

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic known_type(input logic [7:0] t);
    case (t)
      TYPE_DOUBLE, TYPE_FLOAT, TYPE_S32, TYPE_S16, TYPE_S8,
      TYPE_U32, TYPE_U16, TYPE_U8: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // mag * 2^exp2 rounded to nearest even single, sign already in bit 31
  function automatic logic [31:0] round_to_single(input logic [31:0] sign,
                                                   input logic [63:0] mag,
                                                   input int exp2);
    int          p;
    int          fe;
    int          sh;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] bits;
    if (mag == 64'd0) return sign;
    p = 63;
    while (!mag[p]) p--;
    fe = p + exp2 + 127;
    if (fe >= 255) return sign | 32'h7F80_0000;
    sh = (fe >= 1) ? p - 23 : p - 23 + (1 - fe);
    if (sh > 64) return sign;
    if (sh <= 0) begin
      q = mag << (-sh);
    end else begin
      q = (sh == 64) ? 64'd0 : mag >> sh;
      rem = (sh == 64) ? mag : mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
    end
    if (fe >= 1) begin
      bits = (32'(fe - 1) << 23) + q[31:0];
      if (bits >= 32'h7F80_0000) bits = 32'h7F80_0000;
    end else begin
      bits = q[31:0];
    end
    return sign | bits;
  endfunction

  function automatic logic [31:0] int_to_single(input logic [63:0] raw, input int width,
                                                input logic is_signed);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (64'd1 << width) - 64'd1;
    v = raw & mask;
    if (is_signed && v[width-1])
      return round_to_single(32'h8000_0000, (~v + 64'd1) & mask, 0);
    return round_to_single(32'd0, v, 0);
  endfunction

  function automatic logic [31:0] element_to_single(input logic [63:0] raw,
                                                    input logic [7:0] t);
    logic [31:0] sign;
    logic [10:0] e;
    logic [63:0] m;
    case (t)
      TYPE_DOUBLE: begin
        sign = {raw[63], 31'd0};
        e = raw[62:52];
        m = {12'd0, raw[51:0]};
        if (e == 11'h7FF) begin
          if (m == 64'd0) return sign | 32'h7F80_0000;
          return sign | 32'h7FC0_0000 | 32'(m >> 29);  // quiet nan, top payload kept
        end
        if (e != 11'd0) m[52] = 1'b1;
        return round_to_single(sign, m, ((e != 0) ? int'(e) : 1) - 1075);
      end
      TYPE_FLOAT: return raw[31:0];
      TYPE_S32: return int_to_single(raw, 32, 1'b1);
      TYPE_S16: return int_to_single(raw, 16, 1'b1);
      TYPE_S8: return int_to_single(raw, 8, 1'b1);
      TYPE_U32: return int_to_single(raw, 32, 1'b0);
      TYPE_U16: return int_to_single(raw, 16, 1'b0);
      default: return int_to_single(raw, 8, 1'b0);
    endcase
  endfunction

  // advances the walk state for one accepted item; returns 0 when ignored
  function automatic logic predict_gather_step(input logic act, input logic [31:0] st,
                                               input logic [31:0] cnt,
                                               input logic [63:0] raw,
                                               output gather_res_t r);
    logic [63:0] rl;
    logic [63:0] istep;
    logic [63:0] ostep;
    logic [63:0] k;
    logic [63:0] slot;
    rl = (p_rowlen == 0) ? 64'd1 : {32'd0, p_rowlen};  // zero row length acts as one
    istep = {{32{p_istride[31]}}, p_istride};
    ostep = {{32{p_ostride[31]}}, p_ostride};
    r = '0;
    if (act == 1'b0) begin
      run_active = 1'b0;  // a start always drops any run in progress
      if (!known_type(p_etype)) begin
        r.err = 1'b1;
      end else if (cnt == 0) begin
        r.done = 1'b1;
      end else begin
        col_pos = 32'({32'd0, st} % rl);
        row_addr = 48'({16'd0, p_base} + ({32'd0, st} / rl) * ostep);
        elem_addr = 48'({16'd0, row_addr} + {32'd0, col_pos} * istep);
        done_cnt = 0;
        run_len = cnt;
        run_active = 1'b1;
        r.fv = 1'b1;
        r.addr = elem_addr;
      end
      return 1'b1;
    end
    if (!run_active) return 1'b0;  // data with no run is dropped
    if (!known_type(p_etype)) begin
      run_active = 1'b0;
      r.err = 1'b1;
      return 1'b1;
    end
    k = {32'd0, done_cnt};
    r.vv = 1'b1;
    r.val = element_to_single(raw, p_etype);
    slot = (k / 8) * 8 * {48'd0, p_atotal} + 8 * {48'd0, p_anum} + k % 8;
    r.slot = slot[47:0];
    done_cnt = done_cnt + 1;
    if (done_cnt == run_len) begin
      run_active = 1'b0;
      r.done = 1'b1;
    end else begin
      col_pos = col_pos + 1;
      // past the row end (also after a mid-run shrink) go to the next row start
      if ({32'd0, col_pos} >= rl) begin
        col_pos = 0;
        row_addr = 48'({16'd0, row_addr} + ostep);
        elem_addr = row_addr;
      end else begin
        elem_addr = 48'({16'd0, elem_addr} + istep);
      end
      r.fv = 1'b1;
      r.addr = elem_addr;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  // drives one item and waits for it to be taken, then logs the prediction
  task automatic send_item(input logic act, input logic [31:0] st, input logic [31:0] cnt,
                           input logic [63:0] raw, input logic typed,
                           input gather_res_t want);
    gather_res_t r;
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    start_element <= st;
    element_count <= cnt;
    raw_element <= raw;
    do @(posedge clk); while (in_stall);
    if (predict_gather_step(act, st, cnt, raw, r)) begin
      pending_results.push_back(typed ? want : r);
      item_count++;
    end
  endtask

  // sender holds off until every result is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_BASE: p_base = data;
      REG_ROWLEN: p_rowlen = data[31:0];
      REG_ISTRIDE: p_istride = data[31:0];
      REG_OSTRIDE: p_ostride = data[31:0];
      REG_TYPE: p_etype = data[7:0];
      REG_ATOTAL: p_atotal = data[15:0];
      REG_ANUM: p_anum = data[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_raw();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v[62:52] = 11'h7FF;                             // inf or nan
      1: v[62:52] = 11'h000;                             // subnormal or zero
      2: v[62:52] = 11'(1023 + $urandom_range(0, 300) - 150);  // single range edges
      3: v[62:52] = 11'(1023 + $urandom_range(0, 40) - 20);
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_config(input bit all_regs);
    logic [47:0] v;
    if (all_regs || $urandom_range(1)) begin
      case ($urandom_range(3))
        0: v = 48'd0;
        1: v = 48'hFFFF_FFFF_FFFF;
        default: v = {$urandom, $urandom};
      endcase
      write_reg(REG_BASE, v);
    end
    if (all_regs || $urandom_range(1)) begin
      case ($urandom_range(5))
        0: v = 48'd0;
        1: v = 48'd1;
        2: v = 48'hFFFF_FFFF;
        3: v = {16'd0, $urandom};
        default: v = 48'($urandom_range(2, 10));
      endcase
      write_reg(REG_ROWLEN, v);
    end
    if (all_regs || $urandom_range(1))
      write_reg(REG_ISTRIDE, $urandom_range(1) ? {16'd0, pick_word()} : 48'($urandom_range(16)));
    if (all_regs || $urandom_range(1))
      write_reg(REG_OSTRIDE, {16'd0, pick_word()});
    if (all_regs || $urandom_range(1)) begin
      case ($urandom_range(9))
        0: v = 48'($urandom_range(255));
        1: v = 48'(TYPE_DOUBLE);
        2: v = 48'(TYPE_FLOAT);
        3: v = 48'(TYPE_S32);
        4: v = 48'(TYPE_S16);
        5: v = 48'(TYPE_S8);
        6: v = 48'(TYPE_U32);
        7: v = 48'(TYPE_U16);
        8: v = 48'(TYPE_U8);
        default: v = 48'(TYPE_DOUBLE);
      endcase
      write_reg(REG_TYPE, v);
    end
    if (all_regs || $urandom_range(1))
      write_reg(REG_ATOTAL, $urandom_range(1) ? 48'($urandom_range(1, 5)) : 48'(pick_word()));
    if (all_regs || $urandom_range(1))
      write_reg(REG_ANUM, $urandom_range(1) ? 48'($urandom_range(0, 4)) : 48'(pick_word()));
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    gather_res_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        w = pending_results.pop_front();
        check_field("fetch_valid", 64'(w.fv), 64'(fetch_valid));
        check_field("fetch_address", 64'(w.addr), 64'(fetch_address));
        check_field("value_valid", 64'(w.vv), 64'(value_valid));
        check_field("converted_value", 64'(w.val), 64'(converted_value));
        check_field("dest_slot", 64'(w.slot), 64'(dest_slot));
        check_field("done_res", 64'(w.done), 64'(done_res));
        check_field("type_error", 64'(w.err), 64'(type_error));
      end
    end
  end

  // receiver stalls at random outside the calm stretch
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 22);
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    int          n_data;
    int          stop_at;
    logic [31:0] st;
    logic [31:0] cnt;
    rst = 1'b1;
    in_valid = 1'b0;
    action = 1'b0;
    start_element = '0;
    element_count = '0;
    raw_element = '0;
    cfg_write = 1'b0;
    cfg_index = REG_BASE;
    cfg_data = '0;
    out_stall = 1'b0;
    calm = 1'b0;
    fail_count = 0;
    item_count = 0;
    idle_cycles = 0;
    // reset values
    p_base = '0;
    p_rowlen = 32'd1;
    p_istride = '0;
    p_ostride = '0;
    p_etype = TYPE_DOUBLE;
    p_atotal = 16'd1;
    p_anum = '0;
    row_addr = '0;
    elem_addr = '0;
    col_pos = '0;
    done_cnt = '0;
    run_len = '0;
    run_active = 1'b0;

    // directed table, run under the reset configuration apart from the type
    stim_rows.push_back('{TYPE_DOUBLE, 1'b0, 32'd0, 32'd1, 64'd0, 1'b1, '{1, 0, 0, 0, 0, 0, 0}});
    stim_rows.push_back('{TYPE_DOUBLE, 1'b1, 32'd0, 32'd0, 64'h3FF0_0000_0000_0000, 1'b1,
                          '{0, 0, 1, 32'h3F80_0000, 0, 1, 0}});
    // data with no run: dropped
    stim_rows.push_back('{TYPE_DOUBLE, 1'b1, 32'd0, 32'd0, 64'h1234, 1'b0, '0});
    // zero count: done only
    stim_rows.push_back('{TYPE_DOUBLE, 1'b0, 32'd5, 32'd0, 64'd0, 1'b1, '{0, 0, 0, 0, 0, 1, 0}});
    stim_rows.push_back('{TYPE_DOUBLE, 1'b0, 32'hFFFF_FFFF, 32'd6, 64'd0, 1'b0, '0});
    stim_rows.push_back('{TYPE_DOUBLE, 1'b1, 32'd0, 32'd0, 64'h7FF0_0000_0000_0000, 1'b1,
                          '{1, 0, 1, 32'h7F80_0000, 0, 0, 0}});
    stim_rows.push_back('{TYPE_DOUBLE, 1'b1, 32'd0, 32'd0, 64'hFFF8_0000_2000_0000, 1'b0, '0});
    stim_rows.push_back('{TYPE_DOUBLE, 1'b1, 32'd0, 32'd0, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0, '0});
    stim_rows.push_back('{TYPE_DOUBLE, 1'b1, 32'd0, 32'd0, 64'h0000_0000_0000_0001, 1'b0, '0});
    stim_rows.push_back('{TYPE_DOUBLE, 1'b1, 32'd0, 32'd0, 64'h8000_0000_0000_0000, 1'b0, '0});
    stim_rows.push_back('{TYPE_DOUBLE, 1'b1, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0});
    stim_rows.push_back('{TYPE_S8, 1'b0, 32'd0, 32'd2, 64'd0, 1'b0, '0});
    stim_rows.push_back('{TYPE_S8, 1'b1, 32'd0, 32'd0, 64'h80, 1'b1,
                          '{1, 0, 1, 32'hC300_0000, 0, 0, 0}});
    stim_rows.push_back('{TYPE_S8, 1'b1, 32'd0, 32'd0, 64'h7F, 1'b1,
                          '{0, 0, 1, 32'h42FE_0000, 1, 1, 0}});
    stim_rows.push_back('{TYPE_U8, 1'b0, 32'd0, 32'd1, 64'd0, 1'b0, '0});
    stim_rows.push_back('{TYPE_U8, 1'b1, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                          '{0, 0, 1, 32'h437F_0000, 0, 1, 0}});
    stim_rows.push_back('{TYPE_S32, 1'b0, 32'd0, 32'd2, 64'd0, 1'b0, '0});
    stim_rows.push_back('{TYPE_S32, 1'b1, 32'd0, 32'd0, 64'h8000_0000, 1'b0, '0});
    stim_rows.push_back('{TYPE_S32, 1'b1, 32'd0, 32'd0, 64'hFFFF_FFFF_7FFF_FFFF, 1'b0, '0});
    stim_rows.push_back('{TYPE_U32, 1'b0, 32'd0, 32'd1, 64'd0, 1'b0, '0});
    stim_rows.push_back('{TYPE_U32, 1'b1, 32'd0, 32'd0, 64'hFFFF_FFFF, 1'b1,
                          '{0, 0, 1, 32'h4F80_0000, 0, 1, 0}});
    // one run crossing three types
    stim_rows.push_back('{TYPE_S16, 1'b0, 32'd0, 32'd3, 64'd0, 1'b0, '0});
    stim_rows.push_back('{TYPE_S16, 1'b1, 32'd0, 32'd0, 64'h8000, 1'b0, '0});
    stim_rows.push_back('{TYPE_U16, 1'b1, 32'd0, 32'd0, 64'hFFFF, 1'b0, '0});
    stim_rows.push_back('{TYPE_FLOAT, 1'b1, 32'd0, 32'd0, 64'hFFFF_FFFF_1234_5678, 1'b1,
                          '{0, 0, 1, 32'h1234_5678, 2, 1, 0}});
    // unknown type at start, then at data time
    stim_rows.push_back('{TYPE_UNKNOWN, 1'b0, 32'd0, 32'd1, 64'd0, 1'b1,
                          '{0, 0, 0, 0, 0, 0, 1}});
    stim_rows.push_back('{TYPE_FLOAT, 1'b0, 32'd0, 32'd2, 64'd0, 1'b0, '0});
    stim_rows.push_back('{TYPE_UNKNOWN, 1'b1, 32'd0, 32'd0, 64'd1, 1'b1,
                          '{0, 0, 0, 0, 0, 0, 1}});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      // type switches only once the block has gone quiet
      if (stim_rows[i].etype != p_etype) begin
        drain();
        write_reg(REG_TYPE, 48'(stim_rows[i].etype));
      end
      send_item(stim_rows[i].act, stim_rows[i].st, stim_rows[i].cnt, stim_rows[i].raw,
                stim_rows[i].typed, stim_rows[i].want);
    end

    // random runs: each phase may reprogram the walk, then one to four gathers
    item_count = 0;
    drain();
    random_config(1'b1);
    while (item_count < RANDOM_ITEMS) begin
      calm = (item_count >= 150 && item_count < 240);
      drain();
      random_config(1'b0);
      repeat ($urandom_range(1, 4)) begin
        // stray data, dropped unless a run is still open
        if ($urandom_range(9) == 0)
          send_item(1'b1, $urandom, $urandom, pick_raw(), 1'b0, '0);
        st = ($urandom_range(4) == 0) ? pick_word() : 32'($urandom_range(0, 100));
        case ($urandom_range(19))
          0: cnt = 32'd0;
          1: cnt = pick_word();
          default: cnt = 32'($urandom_range(1, 12));
        endcase
        send_item(1'b0, st, cnt, {$urandom, $urandom}, 1'b0, '0);
        n_data = (cnt > 32'd12) ? $urandom_range(1, 12) : int'(cnt);
        if ($urandom_range(7) == 0) n_data = $urandom_range(0, n_data);  // abandoned run
        stop_at = ($urandom_range(9) == 0) ? $urandom_range(0, n_data) : -1;
        for (int j = 0; j < n_data; j++) begin
          // occasional mid-run change of row length or type
          if (j == stop_at) begin
            drain();
            if ($urandom_range(1)) write_reg(REG_ROWLEN, 48'($urandom_range(0, 3)));
            else write_reg(REG_TYPE, 48'($urandom_range(255)));
          end
          send_item(1'b1, $urandom, $urandom, pick_raw(), 1'b0, '0);
        end
      end
    end
    calm = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
